FILE: sv/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants for the MIDI clock divider
// Holds the MIDI status codes, the register map, the command kinds passed
// from the classifier to the executor, and the default queue depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcd_pkg;

  // MIDI real-time status bytes handled by the block
  localparam logic [7:0] MIDI_CLOCK = 8'hF8;
  localparam logic [7:0] MIDI_START = 8'hFA;
  localparam logic [7:0] MIDI_STOP  = 8'hFC;

  // Register map: register index, selected by paddr[2]
  localparam logic REG_DIVIDE_RATIO = 1'b0;
  localparam logic REG_START_DELAY  = 1'b1;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned RATIO_W  = 6;
  localparam int unsigned DELAY_W  = 7;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 6'd1;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 7'd0;

  // Default command queue depth (power of two)
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_CLOCK = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_OTHER = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/mcd_front.sv
// ----------------------------------------------------------------------------
// mcd_front: input classifier
// Accepts raw MIDI bytes and tags each one as clock, start, stop or other
// before pushing it into the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcd_front
  import mcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_full,
  output logic            push,
  output cmd_t            push_cmd
);

  cmd_kind_t kind;

  always_comb begin
    unique case (in_byte)
      MIDI_CLOCK: kind = KIND_CLOCK;
      MIDI_START: kind = KIND_START;
      MIDI_STOP:  kind = KIND_STOP;
      default:    kind = KIND_OTHER;
    endcase
  end

  // Hold the source off while the queue has no room
  assign in_stall      = q_full;
  assign push          = in_valid && !q_full;
  assign push_cmd.kind = kind;
  assign push_cmd.data = in_byte;

  // A push must only happen into a queue with room
  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("mcd_front: push into full queue");

endmodule

`default_nettype wire

FILE: sv/mcd_queue.sv
// ----------------------------------------------------------------------------
// mcd_queue: command queue
// Small FIFO between the classifier and the executor so each side can stall
// on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcd_queue
  import mcd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      q_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          entries [DEPTH];
  logic [AW:0]   wr_ptr;
  logic [AW:0]   rd_ptr;
  logic [AW:0]   fill;

  assign fill    = wr_ptr - rd_ptr;
  assign full    = (fill == (AW+1)'(DEPTH));
  assign q_valid = (fill != '0);
  assign pop_cmd = entries[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == (AW+1)'(2*DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == (AW+1)'(2*DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr[AW-1:0]] <= push_cmd;
    end
  end

  // Occupancy never exceeds the depth, and pops only come from a filled queue
  assert property (@(posedge clk) disable iff (rst) fill <= (AW+1)'(DEPTH))
    else $error("mcd_queue: occupancy overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("mcd_queue: pop from empty queue");

endmodule

`default_nettype wire

FILE: sv/mcd_back.sv
// ----------------------------------------------------------------------------
// mcd_back: clock divider executor
// Pops classified commands, updates tick, delay and run state, and drives
// zero, one or two result bytes through an output register and a spare slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcd_back
  import mcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [RATIO_W-1:0] divide_ratio,
  input  wire logic [DELAY_W-1:0] start_delay_ticks,
  input  wire logic               q_valid,
  input  wire cmd_t               pop_cmd,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    last
);

  logic [RATIO_W-1:0] tick_count;
  logic [DELAY_W-1:0] delay_count;
  logic               running;
  logic               sec_valid;   // a clock byte waits behind the output reg

  logic [RATIO_W-1:0] tick_count_next;
  logic [DELAY_W-1:0] delay_count_next;
  logic               running_next;

  logic [RATIO_W-1:0] eff_ratio;
  logic [RATIO_W-1:0] tick_inc;
  logic [DELAY_W-1:0] delay_dec;
  logic               start_emit;
  logic               run_now;
  logic               clk_emit;
  logic [1:0]         n_out;
  logic [7:0]         first_byte;
  logic               out_free;

  assign eff_ratio  = (divide_ratio == '0) ? RATIO_W'(1) : divide_ratio;
  assign tick_inc   = tick_count + 1'b1;
  assign delay_dec  = delay_count - 1'b1;
  assign start_emit = (delay_count != '0) && (delay_dec == '0);
  assign run_now    = running || start_emit;
  assign clk_emit   = run_now && (tick_inc >= eff_ratio);

  always_comb begin
    tick_count_next  = tick_count;
    delay_count_next = delay_count;
    running_next     = running;
    n_out            = 2'd0;
    first_byte       = pop_cmd.data;
    unique case (pop_cmd.kind)
      KIND_CLOCK: begin
        if (delay_count != '0) begin
          delay_count_next = delay_dec;
        end
        running_next = run_now;
        if (run_now) begin
          tick_count_next = clk_emit ? '0 : tick_inc;
        end
        n_out      = {1'b0, start_emit} + {1'b0, clk_emit};
        first_byte = start_emit ? MIDI_START : MIDI_CLOCK;
      end
      KIND_START: begin
        // Preset so the first tick passes, then load the delay
        tick_count_next  = eff_ratio - 1'b1;
        delay_count_next = start_delay_ticks;
        if (start_delay_ticks == '0) begin
          running_next = 1'b1;
          n_out        = 2'd1;
        end
        first_byte = MIDI_START;
      end
      KIND_STOP: begin
        running_next = 1'b0;
        n_out        = 2'd1;
      end
      default: begin
        n_out = 2'd1;
      end
    endcase
  end

  assign out_free = !out_valid || !out_stall;
  assign pop      = q_valid && !sec_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      delay_count <= '0;
      running     <= 1'b0;
      out_valid   <= 1'b0;
      sec_valid   <= 1'b0;
    end else begin
      if (pop) begin
        tick_count  <= tick_count_next;
        delay_count <= delay_count_next;
        running     <= running_next;
        out_valid   <= (n_out != 2'd0);
        sec_valid   <= (n_out == 2'd2);
      end else if (sec_valid && out_free) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte <= first_byte;
      last     <= (n_out == 2'd1);
    end else if (sec_valid && out_free) begin
      out_byte <= MIDI_CLOCK;
      last     <= 1'b1;
    end
  end

  // The spare slot only fills behind a byte still on the output
  assert property (@(posedge clk) disable iff (rst) sec_valid |-> out_valid)
    else $error("mcd_back: spare slot without output");
  // A non-final byte always has its partner waiting
  assert property (@(posedge clk) disable iff (rst) (out_valid && !last) |-> sec_valid)
    else $error("mcd_back: non-final byte without follower");
  // STOP always leaves the divider stopped
  assert property (@(posedge clk) disable iff (rst)
                   (pop && pop_cmd.kind == KIND_STOP) |=> !running)
    else $error("mcd_back: still running after STOP");

endmodule

`default_nettype wire

FILE: sv/midi_clock_divider_delayed_start_top.sv
// Path: a result byte passes through the command queue and then the output
//   register; a second byte (START followed by clock) waits in the spare slot
//   and follows once the output register is free.
// Throughput: one input per cycle for zero- or one-byte inputs unless stalled;
//   a two-byte input holds off the next; one output register sets this.
// Reset: synchronous, clears the queue, output, tick/delay counters and the
//   run flag; divide_ratio returns to 1 and start_delay_ticks to 0.
// ----------------------------------------------------------------------------
// midi_clock_divider_delayed_start_top: MIDI clock divider with delayed start
// Forwards a MIDI byte stream, thinning timing clock bytes by a programmable
// ratio and holding START back for a programmable number of ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_clock_divider_delayed_start_top
  import mcd_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input byte channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_byte,
  // output byte channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    last,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  // Configuration registers
  logic [RATIO_W-1:0] divide_ratio;
  logic [DELAY_W-1:0] start_delay_ticks;
  logic               cfg_write;
  logic               reg_sel;

  // Front to queue to back
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  logic pop;
  cmd_t pop_cmd;

  // Register select: one 32-bit register every four bytes
  assign reg_sel   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_ratio      <= RATIO_RESET;
      start_delay_ticks <= DELAY_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_DIVIDE_RATIO: divide_ratio      <= pwdata[RATIO_W-1:0];
        REG_START_DELAY:  start_delay_ticks <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register, zero-extended
  always_comb begin
    unique case (reg_sel)
      REG_DIVIDE_RATIO: prdata = PDATA_W'(divide_ratio);
      REG_START_DELAY:  prdata = PDATA_W'(start_delay_ticks);
      default:          prdata = '0;
    endcase
  end

  // Classify incoming bytes and push them as commands
  mcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple the classifier from the executor
  mcd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_cmd  (pop_cmd)
  );

  // Advance the divider state and drive the result bytes
  mcd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .divide_ratio      (divide_ratio),
    .start_delay_ticks (start_delay_ticks),
    .q_valid           (q_valid),
    .pop_cmd           (pop_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .last              (last)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the MIDI clock divider with delayed start
// Drives MIDI bytes through the valid/stall input channel. A bit-accurate
// model of the divider predicts the outgoing bytes, and each output
// transaction is checked against them in order. A short directed table
// comes first, then random phases with different register settings and
// idle patterns. One phase includes a long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_top;
  import mcd_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_CYC   = 12;
  localparam int SETTLE_CYC  = 8;       // lets zero-result bytes drain out of the block
  localparam int HOLD_CYC    = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } midi_out_t;

  typedef enum logic [1:0] {
    ROW_WRITE,    // register write, taken only while the block is idle
    ROW_TYPED,    // byte whose outgoing bytes are given in the row
    ROW_PREDICT   // byte checked against the divider model
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic       rindex;
    logic [31:0] value;
    logic [7:0] data;
    logic [1:0] n_exp;
    logic [7:0] exp0;
    logic [7:0] exp1;
  } stim_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [5:0]  ratio;
    logic [6:0]  delay;
    logic [15:0] n_items;
    logic [7:0]  start_pct;
    logic [7:0]  clock_pct;
    idle_mode_t  mode;
    logic        hold_off;
  } phase_t;

  // DUT ports
  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_byte;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_byte;
  logic               last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Divider model state and its copy of the registers
  logic [RATIO_W-1:0] cfg_ratio;
  logic [DELAY_W-1:0] cfg_delay;
  logic [5:0]         tick_cnt;
  logic [6:0]         delay_left;
  logic               is_running;

  midi_out_t pending_tx[$];   // outgoing bytes still owed by the block
  stim_row_t dir_rows[$];
  phase_t    phases[$];

  int mismatches  = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left   = 0;
  bit hold_go     = 1'b0;

  midi_clock_divider_delayed_start_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Divider model: one incoming byte in, up to two outgoing bytes out.
  // The clock byte counts down a pending delayed start first, so it can
  // yield START followed by clock.
  // --------------------------------------------------------------------------
  function automatic int thin_midi_byte(input logic [7:0] b, output midi_out_t [1:0] res);
    int         n;
    logic [5:0] eff;
    n   = 0;
    res = '0;
    // a zero ratio lets every tick through
    eff = (cfg_ratio == '0) ? 6'd1 : cfg_ratio;
    if (b == MIDI_CLOCK) begin
      if (delay_left != '0) begin
        delay_left = delay_left - 7'd1;
        if (delay_left == '0) begin
          res[n].data = MIDI_START;
          n++;
          is_running = 1'b1;
        end
      end
      if (is_running) begin
        tick_cnt = tick_cnt + 6'd1;
        // greater-or-equal: a ratio lowered below the count fires at once
        if (tick_cnt >= eff) begin
          res[n].data = MIDI_CLOCK;
          n++;
          tick_cnt = '0;
        end
      end
    end else if (b == MIDI_START) begin
      // preset so the first tick after the start passes through
      tick_cnt   = eff - 6'd1;
      delay_left = cfg_delay;
      if (delay_left == '0) begin
        res[n].data = MIDI_START;
        n++;
        is_running = 1'b1;
      end
    end else begin
      if (b == MIDI_STOP) begin
        is_running = 1'b0;
      end
      res[n].data = b;
      n++;
    end
    if (n > 0) begin
      res[n-1].last = 1'b1;
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Output checker: compare every accepted output transaction with the
  // oldest owed byte.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    midi_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tx.size() == 0) begin
        $display("%0t tb_top: unexpected output out_byte %02h last %0b (nothing expected)",
                 $time, out_byte, last);
        mismatches++;
      end else begin
        want = pending_tx.pop_front();
        if (out_byte !== want.data || last !== want.last) begin
          $display({"%0t tb_top: mismatch expected out_byte %02h last %0b,",
                    " got out_byte %02h last %0b"},
                   $time, want.data, want.last, out_byte, last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per idle mode, or a long hold-off on request.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYC - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Offer one byte, with random idle cycles ahead of it; return at the
  // edge where the transaction is accepted.
  task automatic drive_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Drive a byte and record the outgoing bytes it owes.
  task automatic send_and_predict(input logic [7:0] b);
    midi_out_t [1:0] res;
    int              n;
    drive_byte(b);
    n = thin_midi_byte(b, res);
    for (int i = 0; i < n; i++) begin
      pending_tx.push_back(res[i]);
    end
  endtask

  // Drop valid so the last byte is not taken again, wait until every owed
  // byte has come out, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tx.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register write in a setup and an access phase; the model takes the value at the write edge.
  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (idx == REG_DIVIDE_RATIO) begin
      cfg_ratio = val[RATIO_W-1:0];
    end else begin
      cfg_delay = val[DELAY_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct  = 83;
        rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 83;
      end
      default: begin
        tx_idle_pct  = 20;
        rx_stall_pct = 20;
      end
    endcase
  endtask

  function automatic logic [7:0] pick_byte(input int start_pct, input int clock_pct);
    int r;
    r = $urandom_range(99);
    if (r < clock_pct) begin
      return MIDI_CLOCK;
    end else if (r < clock_pct + start_pct) begin
      return MIDI_START;
    end else if (r < clock_pct + start_pct + 3) begin
      return MIDI_STOP;
    end
    return 8'($urandom_range(255));
  endfunction

  // Table builders
  task automatic add_write(input logic idx, input logic [31:0] val);
    stim_row_t row;
    row        = '0;
    row.kind   = ROW_WRITE;
    row.rindex = idx;
    row.value  = val;
    dir_rows.push_back(row);
  endtask

  task automatic add_typed(input logic [7:0] b, input logic [1:0] n,
                           input logic [7:0] e0, input logic [7:0] e1);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_TYPED;
    row.data  = b;
    row.n_exp = n;
    row.exp0  = e0;
    row.exp1  = e1;
    dir_rows.push_back(row);
  endtask

  task automatic add_predict(input logic [7:0] b);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_PREDICT;
    row.data = b;
    dir_rows.push_back(row);
  endtask

  task automatic add_phase(input logic [5:0] ratio, input logic [6:0] delay,
                           input int n_items, input int start_pct, input int clock_pct,
                           input idle_mode_t mode, input logic hold_off);
    phase_t ph;
    ph.ratio     = ratio;
    ph.delay     = delay;
    ph.n_items   = 16'(n_items);
    ph.start_pct = 8'(start_pct);
    ph.clock_pct = 8'(clock_pct);
    ph.mode      = mode;
    ph.hold_off  = hold_off;
    phases.push_back(ph);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t       row;
    phase_t          ph;
    midi_out_t [1:0] res;
    midi_out_t       typed;
    logic [31:0]     wdata;
    int              n;

    // drive every input to a known value from time zero
    rst     = 1'b1;
    in_valid = 1'b0;
    in_byte = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // model state after reset
    cfg_ratio  = RATIO_RESET;
    cfg_delay  = DELAY_RESET;
    tick_cnt   = '0;
    delay_left = '0;
    is_running = 1'b0;

    // Directed table: rows with typed results are plain to read off the
    // reset state and the extremes; the rest go through the model.
    add_typed(8'h00, 2'd1, 8'h00, 8'h00);              // lowest byte forwarded
    add_typed(8'hFF, 2'd1, 8'hFF, 8'h00);              // highest byte forwarded
    add_typed(MIDI_CLOCK, 2'd0, 8'h00, 8'h00);         // clock while stopped: dropped
    add_typed(MIDI_START, 2'd1, MIDI_START, 8'h00);    // start at once
    add_typed(MIDI_CLOCK, 2'd1, MIDI_CLOCK, 8'h00);    // ratio 1: every tick
    add_typed(MIDI_STOP, 2'd1, MIDI_STOP, 8'h00);
    add_write(REG_DIVIDE_RATIO, 32'd0);                // zero ratio acts as one
    add_typed(MIDI_START, 2'd1, MIDI_START, 8'h00);
    add_typed(MIDI_CLOCK, 2'd1, MIDI_CLOCK, 8'h00);
    add_write(REG_DIVIDE_RATIO, 32'd63);               // ratio above the usual range
    add_typed(MIDI_START, 2'd1, MIDI_START, 8'h00);
    add_typed(MIDI_CLOCK, 2'd1, MIDI_CLOCK, 8'h00);    // first tick passes
    add_predict(MIDI_CLOCK);
    add_predict(MIDI_CLOCK);
    add_predict(MIDI_CLOCK);
    add_write(REG_DIVIDE_RATIO, 32'd2);                // lower ratio under the count
    add_predict(MIDI_CLOCK);
    add_write(REG_START_DELAY, 32'd2);
    add_predict(MIDI_START);                           // delayed start: silent
    add_predict(MIDI_CLOCK);
    add_predict(MIDI_START);                           // reload a pending delay
    add_predict(MIDI_STOP);                            // stop while a delay is pending
    add_predict(MIDI_CLOCK);
    add_predict(MIDI_CLOCK);                           // START then clock
    add_write(REG_START_DELAY, 32'd127);               // delay above the usual range
    add_predict(MIDI_START);
    add_write(REG_DIVIDE_RATIO, 32'd32);
    add_write(REG_START_DELAY, 32'd96);
    add_predict(8'h55);
    add_predict(8'hAA);

    // Random phases: settings cover the extremes, each idle mode gets
    // its turn, and large delays get long clock-heavy runs so they expire.
    add_phase(6'd1,  7'd0,   40, 10, 60, IDLE_NONE,     1'b0);
    add_phase(6'd32, 7'd3,   50,  8, 70, IDLE_SENDER,   1'b0);
    add_phase(6'd0,  7'd96, 130,  0, 90, IDLE_RECEIVER, 1'b0);
    add_phase(6'd63, 7'd127, 160, 0, 92, IDLE_BOTH,     1'b0);
    add_phase(6'($urandom_range(1, 32)), 7'($urandom_range(0, 8)),
              50, 8, 60, IDLE_NONE, 1'b1);
    add_phase(6'($urandom_range(0, 63)), 7'($urandom_range(0, 10)),
              40, 8, 60, IDLE_SENDER, 1'b0);

    // hold reset, release it on a falling edge
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table with no idling
    set_idle(IDLE_NONE);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_WRITE: begin
          wait_drained();
          reg_write(row.rindex, row.value);
        end
        ROW_TYPED: begin
          drive_byte(row.data);
          // advance the model state; the row gives the results
          n = thin_midi_byte(row.data, res);
          for (int k = 0; k < row.n_exp; k++) begin
            typed.data = (k == 0) ? row.exp0 : row.exp1;
            typed.last = (k == row.n_exp - 1);
            pending_tx.push_back(typed);
          end
        end
        default: begin
          send_and_predict(row.data);
        end
      endcase
    end

    // Random phases
    foreach (phases[p]) begin
      ph = phases[p];
      wait_drained();
      set_idle(IDLE_NONE);
      // garbage in the upper data bits must be ignored
      wdata = $urandom;
      wdata[RATIO_W-1:0] = ph.ratio;
      reg_write(REG_DIVIDE_RATIO, wdata);
      wdata = $urandom;
      wdata[DELAY_W-1:0] = ph.delay;
      reg_write(REG_START_DELAY, wdata);
      set_idle(ph.mode);
      if (ph.hold_off) begin
        // request the long hold-off; the sender keeps offering so the
        // block fills up and stalls its input
        @(posedge clk);
        hold_go = 1'b1;
      end
      // open each phase with a well-formed start
      send_and_predict(MIDI_START);
      for (int k = 1; k < ph.n_items; k++) begin
        send_and_predict(pick_byte(ph.start_pct, ph.clock_pct));
      end
    end

    // drop valid after the last transaction and drain
    @(negedge clk);
    in_valid <= 1'b0;
    set_idle(IDLE_NONE);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mcd_pkg.sv
sv/mcd_front.sv
sv/mcd_queue.sv
sv/mcd_back.sv
sv/midi_clock_divider_delayed_start_top.sv
sim/tb_top.sv
